/* rtl/core/mpt_pkg.sv */
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared types and constants of the 4x4 matrix point transform engine.
// ----------------------------------------------------------------------------
package mpt_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int DIM         = 4;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(DIM);
   localparam int PROD_W      = 2 * DATA_W;
   localparam int SUM_W       = PROD_W + IDX_W;
   localparam int SHIFT_W     = SUM_W - FRAC_BITS;
   localparam int FIFO_DEPTH  = 16;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int REQ_DATA_W  = 2 * IDX_W + (DIM + 1) * DATA_W;
   localparam int REQ_TDATA_W = ((REQ_DATA_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = DIM * DATA_W;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_XFORM = 1'b1
   } mpt_op_type;

   typedef logic signed [DATA_W-1:0] mpt_data_type;
   typedef logic signed [SUM_W-1:0]  mpt_sum_type;

   localparam mpt_data_type COEF_ONE =
      {{(DATA_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam mpt_data_type DATA_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam mpt_data_type DATA_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   // item travelling down the cell chain
   typedef struct packed {
      logic                     valid;
      mpt_op_type               op;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      mpt_data_type             coef;
      mpt_data_type [DIM-1:0]   point;
      mpt_sum_type  [DIM-1:0]   sums;
   } mpt_item_type;

   typedef struct packed {
      mpt_data_type [DIM-1:0]   comp;
      logic                     saturated;
   } mpt_result_type;

endpackage

/* rtl/core/mpt_cell.sv */
// ----------------------------------------------------------------------------
// mpt_cell
// One column of the matrix: applies loads aimed at its column, multiplies its
// point component by the four column coefficients and adds into the row sums.
// ----------------------------------------------------------------------------
module mpt_cell
   import mpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   cell_col,
   input  mpt_item_type       item_in,
   output mpt_item_type       item_out
);

   mpt_data_type              coef_ff [DIM];
   mpt_data_type              coef_in [DIM];
   logic signed [PROD_W-1:0]  prod_ff [DIM];
   logic signed [PROD_W-1:0]  prod_in [DIM];
   mpt_item_type              stage_a_ff;
   mpt_item_type              stage_b_ff;
   mpt_item_type              stage_b_in;
   mpt_data_type              pt;

   assign pt = $signed(item_in.point[cell_col]);

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         coef_in[r] = coef_ff[r];
         prod_in[r] = coef_ff[r] * pt;
      end
      if (item_in.valid && item_in.op == OP_LOAD && item_in.col == cell_col) begin
         coef_in[item_in.row] = item_in.coef;
      end
   end

   always_comb begin
      stage_b_in = stage_a_ff;
      for (int r = 0; r < DIM; r++) begin
         stage_b_in.sums[r] = $signed(stage_a_ff.sums[r]) + SUM_W'(prod_ff[r]);
      end
   end

   // coefficients reset to this column of the identity
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            coef_ff[r] <= (IDX_W'(r) == cell_col) ? COEF_ONE : '0;
         end
      end else begin
         for (int r = 0; r < DIM; r++) begin
            coef_ff[r] <= coef_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < DIM; r++) begin
         prod_ff[r] <= prod_in[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_ff.valid <= 1'b0;
         stage_b_ff.valid <= 1'b0;
      end else begin
         stage_a_ff <= item_in;
         stage_b_ff <= stage_b_in;
      end
   end

   assign item_out = stage_b_ff;

endmodule

/* rtl/core/mpt_sat.sv */
// ----------------------------------------------------------------------------
// mpt_sat
// Drops the fraction bits of the row sums, clips them to 32 bits and flags
// any clipping; passes on transform items only.
// ----------------------------------------------------------------------------
module mpt_sat
   import mpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mpt_item_type       item_in,
   output logic               res_valid,
   output mpt_result_type     res_data
);

   logic              valid_ff;
   logic              valid_in;
   mpt_result_type    res_ff;
   mpt_result_type    res_in;

   assign valid_in = item_in.valid && item_in.op == OP_XFORM;

   always_comb begin
      logic [SHIFT_W-1:0]      shifted;
      logic [SHIFT_W-DATA_W:0] top_bits;
      res_in.saturated = 1'b0;
      for (int r = 0; r < DIM; r++) begin
         shifted  = item_in.sums[r][SUM_W-1:FRAC_BITS];
         top_bits = shifted[SHIFT_W-1:DATA_W-1];
         if ((&top_bits) || !(|top_bits)) begin
            res_in.comp[r] = shifted[DATA_W-1:0];
         end else begin
            res_in.comp[r]   = shifted[SHIFT_W-1] ? DATA_MIN : DATA_MAX;
            res_in.saturated = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res_valid = valid_ff;
   assign res_data  = res_ff;

endmodule

/* rtl/core/mpt_fifo.sv */
// ----------------------------------------------------------------------------
// mpt_fifo
// Result queue between the free-running cell chain and the output channel.
// ----------------------------------------------------------------------------
module mpt_fifo
   import mpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mpt_result_type     push_data,
   input  logic               pop,
   output logic               pop_valid,
   output mpt_result_type     pop_data
);

   mpt_result_type           mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]    count_ff;
   logic [FIFO_CNT_W-1:0]    count_in;
   logic                     do_pop;

   assign do_pop = pop && count_ff != '0;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   assign pop_valid = count_ff != '0;
   assign pop_data  = mem[rd_ptr_ff];

endmodule

/* rtl/core/matrix4_point_transform_top.sv */
// ----------------------------------------------------------------------------
// matrix4_point_transform_top
// 4x4 Q16.16 matrix by homogeneous point transform, one point per cycle while req_tready is high.
// ----------------------------------------------------------------------------
// Loads and transforms enter one per cycle while req_tready is high and travel
// in order down a chain of four column cells, each a multiply stage and an
// accumulate stage, then a clip stage; a load changes the matrix for every
// later item only. A transform's result leaves through a 16-entry result
// queue; at most 16 transforms may be in flight or queued, so req_tready drops
// only while 16 results are still not taken. The matrix resets to identity.
module matrix4_point_transform_top
   import mpt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // row, col, coef, in_x, in_y, in_z, in_w, zero pad
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // op
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // out_x, out_y, out_z, out_w
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // saturated
   output logic                    rsp_tuser
);

   mpt_item_type             chain [DIM+1];
   mpt_item_type             head_item;
   logic [FIFO_CNT_W-1:0]    credit_ff;
   logic [FIFO_CNT_W-1:0]    credit_in;
   logic                     req_accept;
   logic                     rsp_accept;
   logic                     xform_accept;
   logic                     res_valid;
   mpt_result_type           res_data;
   mpt_result_type           q_data;

   assign req_tready   = credit_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign req_accept   = req_tvalid && req_tready;
   assign rsp_accept   = rsp_tvalid && rsp_tready;
   assign xform_accept = req_accept && mpt_op_type'(req_tuser) == OP_XFORM;

   always_comb begin
      credit_in = credit_ff;
      if (xform_accept && !rsp_accept) begin
         credit_in = credit_ff + 1'b1;
      end else if (!xform_accept && rsp_accept) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   always_comb begin
      head_item.valid = req_accept;
      head_item.op    = mpt_op_type'(req_tuser);
      head_item.row   = req_tdata[IDX_W-1:0];
      head_item.col   = req_tdata[2*IDX_W-1:IDX_W];
      head_item.coef  = req_tdata[2*IDX_W +: DATA_W];
      for (int k = 0; k < DIM; k++) begin
         head_item.point[k] = req_tdata[2*IDX_W + (k + 1) * DATA_W +: DATA_W];
         head_item.sums[k]  = '0;
      end
   end

   assign chain[0] = head_item;

   for (genvar k = 0; k < DIM; k++) begin : g_cell
      mpt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_col (IDX_W'(k)),
         .item_in  (chain[k]),
         .item_out (chain[k+1])
      );
   end

   mpt_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .item_in   (chain[DIM]),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   mpt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_data  (q_data)
   );

   assign rsp_tdata = q_data.comp;
   assign rsp_tuser = q_data.saturated;

endmodule

/* rtl/core/mpt_checker.sv */
// ----------------------------------------------------------------------------
// mpt_checker
// Port-level checks of the matrix point transform engine.
// ----------------------------------------------------------------------------
module mpt_checker
   import mpt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic                    req_tuser,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                    rsp_tuser
);

   logic [FIFO_CNT_W-1:0]  pending_ff;
   logic                   xform_acc;
   logic                   rsp_acc;

   assign xform_acc = req_tvalid && req_tready && req_tuser == OP_XFORM;
   assign rsp_acc   = rsp_tvalid && rsp_tready;

   // transforms taken in but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (xform_acc && !rsp_acc) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (!xform_acc && rsp_acc) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed or dropped");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != '0)
      else $error("result item without a pending transform");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      pending_ff == FIFO_CNT_W'(FIFO_DEPTH) |-> !req_tready)
      else $error("item accepted with result queue full");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      pending_ff != FIFO_CNT_W'(FIFO_DEPTH) |-> req_tready)
      else $error("input stalled with room for results");

endmodule

bind matrix4_point_transform_top mpt_checker u_checker (.*);

/* test/tb_matrix4_point_transform_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix4_point_transform_top
// Self-checking bench for the 4x4 Q16.16 matrix point transform engine.
// Coefficient loads and point transforms go in over the request stream, and
// each transform's four row dot products are predicted from a local copy of
// the matrix. The prediction uses the full-width sum, a floor shift and 32-bit
// clipping. Results are checked in order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_matrix4_point_transform_top;
   import mpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // row, col, coef, in_x, in_y, in_z, in_w, zero pad
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   // op
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // out_x, out_y, out_z, out_w
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   // saturated
   logic                    rsp_tuser;

   mpt_data_type            mat_coef [DIM][DIM];
   mpt_result_type          pending_results [$];
   int                      mismatch_count = 0;
   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;

   matrix4_point_transform_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // four row dot products, full-width sum, floor shift, clip to 32 bits
   function automatic mpt_result_type row_dots(input mpt_data_type pt [DIM]);
      mpt_result_type res;
      mpt_sum_type    acc;
      mpt_sum_type    shifted;
      res.saturated = 1'b0;
      for (int r = 0; r < DIM; r++) begin
         acc = '0;
         for (int k = 0; k < DIM; k++)
            acc += mpt_sum_type'(mat_coef[r][k]) * mpt_sum_type'(pt[k]);
         shifted = acc >>> FRAC_BITS;
         if (shifted > mpt_sum_type'(DATA_MAX)) begin
            res.comp[r] = DATA_MAX;
            res.saturated = 1'b1;
         end else if (shifted < mpt_sum_type'(DATA_MIN)) begin
            res.comp[r] = DATA_MIN;
            res.saturated = 1'b1;
         end else begin
            res.comp[r] = shifted[DATA_W-1:0];
         end
      end
      return res;
   endfunction

   // mix of full-range, small, medium and corner values in Q16.16
   function automatic mpt_data_type rand_q16();
      mpt_data_type v;
      v = $urandom;
      case ($urandom_range(5))
         0, 1: ;
         2: v = {{12{v[19]}}, v[19:0]};
         3: v = {{8{v[23]}}, v[23:0]};
         default: begin
            case ($urandom_range(5))
               0: v = DATA_MAX;
               1: v = DATA_MIN;
               2: v = '0;
               3: v = '1;
               4: v = COEF_ONE;
               default: v = -COEF_ONE;
            endcase
         end
      endcase
      return v;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input mpt_op_type op, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input mpt_data_type coef,
                            input mpt_data_type x, input mpt_data_type y,
                            input mpt_data_type z, input mpt_data_type w);
      mpt_data_type pt [DIM];
      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      pt[3] = w;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({w, z, y, x, coef, col, row});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD)
         mat_coef[row][col] = coef;
      else
         pending_results.push_back(row_dots(pt));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic send_load(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            input mpt_data_type coef);
      send_item(OP_LOAD, row, col, coef, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic send_xform(input mpt_data_type x, input mpt_data_type y,
                             input mpt_data_type z, input mpt_data_type w);
      send_item(OP_XFORM, IDX_W'($urandom), IDX_W'($urandom), $urandom, x, y, z, w);
   endtask

   task automatic test_identity_after_reset();
      send_xform(DATA_MAX, DATA_MIN, '0, '1);
      send_xform(32'sd1, -COEF_ONE, COEF_ONE, 32'sh0000_8000);
      send_xform(DATA_MIN, DATA_MAX, '1, '0);
   endtask

   task automatic test_coef_extremes();
      for (int c = 0; c < DIM; c++) send_load(2'd0, c[IDX_W-1:0], DATA_MAX);
      for (int c = 0; c < DIM; c++) send_load(2'd1, c[IDX_W-1:0], DATA_MIN);
      send_load(2'd2, 2'd1, '1);
      send_load(2'd3, 2'd3, -COEF_ONE);
      // largest sums in both directions, clipping and floor rounding
      send_xform(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
      send_xform(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
      send_xform(32'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_xform('1, '1, '1, '1);
   endtask

   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 30)
            send_item(OP_LOAD, IDX_W'($urandom), IDX_W'($urandom), rand_q16(),
                      $urandom, $urandom, $urandom, $urandom);
         else
            send_item(OP_XFORM, IDX_W'($urandom), IDX_W'($urandom), $urandom,
                      rand_q16(), rand_q16(), rand_q16(), rand_q16());
      end
   endtask

   task automatic test_drain_pause();
      send_idle_pct  = 0;
      recv_stall_pct = 27;
      for (int i = 0; i < 12; i++)
         send_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
      wait_drained();
      send_load(IDX_W'($urandom), IDX_W'($urandom), rand_q16());
      send_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
   endtask

   always @(posedge clock) begin
      mpt_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result data %h sat %b", $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            for (int r = 0; r < DIM; r++) begin
               if (rsp_tdata[r*DATA_W +: DATA_W] !== want.comp[r]) begin
                  $display("%0t: component %0d expected %h actual %h", $time, r,
                           want.comp[r], rsp_tdata[r*DATA_W +: DATA_W]);
                  mismatch_count++;
               end
            end
            if (rsp_tuser !== want.saturated) begin
               $display("%0t: saturated expected %b actual %b", $time,
                        want.saturated, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      int quiet_cycles;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      for (int r = 0; r < DIM; r++)
         for (int c = 0; c < DIM; c++)
            mat_coef[r][c] = (r == c) ? COEF_ONE : '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_identity_after_reset();
      test_coef_extremes();
      test_random_traffic(240, 0, 0);
      test_drain_pause();
      test_random_traffic(230, 81, 0);
      test_random_traffic(230, 0, 81);
      test_random_traffic(230, 27, 27);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
